FILE: sv/jsvd_pkg.sv
package jsvd_pkg;

  localparam int MAX_ROWS_DEF = 4;
  localparam int MAX_COLS_DEF = 4;
  localparam int IN_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  localparam logic [31:0] ONE_Q24 = 32'h0100_0000;

  localparam logic [1:0] CFG_ROWS_USED = 2'd0;
  localparam logic [1:0] CFG_COLS_USED = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;
  localparam logic [1:0] CFG_MAX_SWEEPS = 2'd3;

  localparam logic [2:0] RESET_ROWS_USED = 3'd2;
  localparam logic [2:0] RESET_COLS_USED = 3'd3;
  localparam logic [39:0] RESET_THRESHOLD = 40'd2814750;
  localparam logic [7:0] RESET_MAX_SWEEPS = 8'd30;

  typedef struct packed {
    logic [1:0] elem_row;
    logic [1:0] elem_col;
    logic signed [31:0] elem_value;
    logic last_elem;
  } item_t;

  typedef struct packed {
    logic out_kind;
    logic [1:0] out_row;
    logic [1:0] out_col;
    logic signed [31:0] out_value;
    logic [7:0] sweeps_done;
    logic converged;
    logic last_result;
  } res_t;

  // element write classified by the front part
  typedef struct packed {
    logic wr_ok;
    item_t item;
  } cmd_t;

  typedef struct packed {
    logic [2:0] rows_used;
    logic [2:0] cols_used;
    logic [39:0] ortho_threshold;
    logic [7:0] max_sweeps;
  } cfg_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  // round half up from 2^-54 to 2^-24, saturate to 32 bits
  function automatic logic signed [31:0] round_sat(input logic signed [63:0] x);
    logic signed [63:0] v;
    logic signed [33:0] q;
    v = x + 64'sd536870912;
    q = 34'(v >>> 30);
    if (q > 34'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end
    if (q < 34'sh3_8000_0000) begin
      return 32'sh8000_0000;
    end
    return q[31:0];
  endfunction

endpackage

FILE: sv/jsvd_queue.sv
module jsvd_queue #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0] store [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CNTW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = store[head];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[tail] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == PW'(DEPTH - 1)) ? '0 : tail + PW'(1);
      end
      if (do_pop) begin
        head <= (head == PW'(DEPTH - 1)) ? '0 : head + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

FILE: sv/jsvd_front.sv
module jsvd_front import jsvd_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int IN_DEPTH = IN_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t item,
  output logic  full,
  input  logic  cmd_pop,
  output cmd_t  cmd,
  output logic  cmd_empty
);

  cmd_t cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_bits;

  // element outside the stored array is dropped, last flag still starts a run
  always_comb begin
    cmd_in.item = item;
    cmd_in.wr_ok = (int'(item.elem_row) < MAX_ROWS) && (int'(item.elem_col) < MAX_COLS);
  end

  jsvd_queue #(.W($bits(cmd_t)), .DEPTH(IN_DEPTH)) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_bits),
    .empty (cmd_empty)
  );

  assign cmd = cmd_t'(cmd_bits);

endmodule

FILE: sv/jsvd_sqrt.sv
module jsvd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] din,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] x;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [4:0] step;
  logic [63:0] trial;

  assign trial = r + bitv;
  assign root = r[31:0];

  // one result bit per pair of radicand bits, one pair per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 5'd1;
      if (step == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= din;
      r <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (x >= trial) begin
        x <= x - trial;
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

FILE: sv/jsvd_div.sv
module jsvd_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] numer,
  input  logic [31:0] denom,
  output logic        busy,
  output logic [31:0] quot
);

  logic [63:0] n;
  logic [31:0] rem;
  logic [31:0] d;
  logic [5:0] step;
  logic [32:0] shifted;

  assign shifted = {rem, n[63]};
  assign quot = n[31:0];

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 6'd1;
      if (step == 6'd63) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n <= numer;
      rem <= '0;
      d <= denom;
    end else if (busy) begin
      if (shifted >= {1'b0, d}) begin
        rem <= 32'(shifted - {1'b0, d});
        n <= {n[62:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        n <= {n[62:0], 1'b0};
      end
    end
  end

endmodule

FILE: sv/jsvd_back.sv
module jsvd_back import jsvd_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  cmd_t cmd,
  input  logic cmd_empty,
  output logic cmd_pop,
  output logic o_push,
  output res_t o_data,
  input  logic o_full
);

  localparam int VBASE = MAX_ROWS * MAX_COLS;
  localparam int DEPTH = VBASE + MAX_COLS * MAX_COLS;
  localparam int AW = $clog2(DEPTH);
  localparam int MAXD = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int KW = $clog2(MAXD + 1);
  localparam int CW = $clog2(MAX_COLS + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_VINIT = 5'd1;
  localparam logic [4:0] S_SWEEP = 5'd2;
  localparam logic [4:0] S_PRD   = 5'd3;
  localparam logic [4:0] S_PWAIT = 5'd4;
  localparam logic [4:0] S_PAA   = 5'd5;
  localparam logic [4:0] S_PBB   = 5'd6;
  localparam logic [4:0] S_PACC  = 5'd7;
  localparam logic [4:0] S_TEST  = 5'd8;
  localparam logic [4:0] S_NORM  = 5'd9;
  localparam logic [4:0] S_DSQ   = 5'd10;
  localparam logic [4:0] S_QSQ   = 5'd11;
  localparam logic [4:0] S_RSQ   = 5'd12;
  localparam logic [4:0] S_RWAIT = 5'd13;
  localparam logic [4:0] S_DIVST = 5'd14;
  localparam logic [4:0] S_TWAIT = 5'd15;
  localparam logic [4:0] S_TSQ   = 5'd16;
  localparam logic [4:0] S_CSQ   = 5'd17;
  localparam logic [4:0] S_CWAIT = 5'd18;
  localparam logic [4:0] S_CDIV  = 5'd19;
  localparam logic [4:0] S_SMUL  = 5'd20;
  localparam logic [4:0] S_SSET  = 5'd21;
  localparam logic [4:0] S_RRD   = 5'd22;
  localparam logic [4:0] S_RX    = 5'd23;
  localparam logic [4:0] S_RY    = 5'd24;
  localparam logic [4:0] S_RA    = 5'd25;
  localparam logic [4:0] S_RB    = 5'd26;
  localparam logic [4:0] S_RW    = 5'd27;
  localparam logic [4:0] S_NEXT  = 5'd28;
  localparam logic [4:0] S_ERD   = 5'd29;
  localparam logic [4:0] S_EWR   = 5'd30;

  logic [4:0] state;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_a;
  logic signed [31:0] rd_b;
  logic rd_en;
  logic [AW-1:0] ra0;
  logic [AW-1:0] ra1;
  logic we;
  logic [AW-1:0] wa;
  logic signed [31:0] wd;

  logic [KW-1:0] k;
  logic [KW-1:0] k_inc;
  logic [CW-1:0] ci;
  logic [CW-1:0] cj;
  logic seg;
  logic [KW-1:0] nr;
  logic [CW-1:0] nc;
  logic [KW-1:0] lim;

  logic signed [63:0] ip;
  logic signed [63:0] li;
  logic signed [63:0] lj;
  logic signed [63:0] acc;
  logic signed [63:0] t64;
  logic signed [63:0] prod;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;

  logic swp;
  logic neg;
  logic [63:0] dn;
  logic [63:0] qn;
  logic [31:0] den;
  logic [31:0] tm;
  logic [31:0] cs;
  logic signed [31:0] sn;
  logic [63:0] sm_full;
  logic [7:0] sweep_count;
  logic [7:0] count_inc;
  logic sweep_clean;

  logic [63:0] q_abs;
  logic [63:0] d_c;
  logic swp_c;
  logic signed [31:0] x_op;
  logic signed [31:0] y_op;
  logic signed [31:0] dd_op;
  logic signed [31:0] qq_op;

  logic sq_start;
  logic [63:0] sq_din;
  logic sq_busy;
  logic [31:0] sq_root;
  logic dv_start;
  logic [63:0] dv_numer;
  logic [31:0] dv_denom;
  logic dv_busy;
  logic [31:0] dv_quot;

  function automatic logic [AW-1:0] maddr(input logic s, input logic [KW-1:0] r,
                                          input logic [CW-1:0] c);
    return AW'(int'(s) * VBASE + int'(r) * MAX_COLS + int'(c));
  endfunction

  always_comb begin
    if (int'(cfg.rows_used) < 1) begin
      nr = KW'(1);
    end else if (int'(cfg.rows_used) > MAX_ROWS) begin
      nr = KW'(MAX_ROWS);
    end else begin
      nr = KW'(cfg.rows_used);
    end
    if (int'(cfg.cols_used) < 2) begin
      nc = CW'(2);
    end else if (int'(cfg.cols_used) > MAX_COLS) begin
      nc = CW'(MAX_COLS);
    end else begin
      nc = CW'(cfg.cols_used);
    end
  end

  assign k_inc = k + KW'(1);
  assign lim = seg ? KW'(nc) : nr;
  assign count_inc = sweep_count + 8'd1;

  assign q_abs = ip[63] ? 64'(-ip) : 64'(ip);
  assign swp_c = li < lj;
  assign d_c = swp_c ? 64'(lj - li) : 64'(li - lj);
  // the longer column goes first: swapping operands replaces a copy pass
  assign x_op = swp ? rd_b : rd_a;
  assign y_op = swp ? rd_a : rd_b;
  assign dd_op = $signed({2'b00, dn[29:0]});
  assign qq_op = $signed({2'b00, qn[29:0]});
  assign sm_full = 64'((prod + 64'sd536870912) >>> 30);

  jsvd_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .din   (sq_din),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  jsvd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .numer (dv_numer),
    .denom (dv_denom),
    .busy  (dv_busy),
    .quot  (dv_quot)
  );

  // shared multiplier, product registered
  always_comb begin
    mul_a = x_op;
    mul_b = $signed(cs);
    case (state)
      S_PWAIT: begin
        mul_a = rd_a;
        mul_b = rd_b;
      end
      S_PAA: begin
        mul_a = rd_a;
        mul_b = rd_a;
      end
      S_PBB: begin
        mul_a = rd_b;
        mul_b = rd_b;
      end
      S_DSQ: begin
        mul_a = dd_op;
        mul_b = dd_op;
      end
      S_QSQ: begin
        mul_a = qq_op;
        mul_b = qq_op;
      end
      S_TSQ: begin
        mul_a = $signed(tm);
        mul_b = $signed(tm);
      end
      S_SMUL: begin
        mul_a = $signed(cs);
        mul_b = $signed(tm);
      end
      S_RX: begin
        mul_a = x_op;
        mul_b = $signed(cs);
      end
      S_RY: begin
        mul_a = y_op;
        mul_b = sn;
      end
      S_RA: begin
        mul_a = y_op;
        mul_b = $signed(cs);
      end
      S_RB: begin
        mul_a = x_op;
        mul_b = sn;
      end
      default: begin
        mul_a = x_op;
        mul_b = $signed(cs);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    rd_en = 1'b0;
    ra0 = maddr(seg, k, ci);
    ra1 = maddr(seg, k, cj);
    we = 1'b0;
    wa = maddr(seg, k, ci);
    wd = round_sat(acc + prod);
    cmd_pop = 1'b0;
    sq_start = 1'b0;
    sq_din = 64'(t64) + 64'(prod <<< 2);
    dv_start = 1'b0;
    dv_numer = {3'b000, qn[29:0], 31'd0} + 64'(den >> 1);
    dv_denom = den;
    case (state)
      S_IDLE: begin
        cmd_pop = !cmd_empty;
        we = !cmd_empty && cmd.wr_ok;
        wa = maddr(1'b0, KW'(cmd.item.elem_row), CW'(cmd.item.elem_col));
        wd = cmd.item.elem_value;
      end
      S_VINIT: begin
        we = 1'b1;
        wa = maddr(1'b1, k, cj);
        wd = (int'(k) == int'(cj)) ? $signed(ONE_Q24) : 32'sd0;
      end
      S_PRD, S_RRD: begin
        rd_en = 1'b1;
      end
      S_RSQ: begin
        sq_start = 1'b1;
      end
      S_DIVST: begin
        dv_start = 1'b1;
      end
      S_CSQ: begin
        sq_start = 1'b1;
        sq_din = 64'h1000_0000_0000_0000 + 64'(prod);
      end
      S_CWAIT: begin
        dv_start = !sq_busy;
        dv_numer = 64'h1000_0000_0000_0000 + 64'(sq_root >> 1);
        dv_denom = sq_root;
      end
      S_RA: begin
        we = 1'b1;
        wa = maddr(seg, k, ci);
        wd = round_sat(acc + prod);
      end
      S_RW: begin
        we = 1'b1;
        wa = maddr(seg, k, cj);
        wd = round_sat(acc - prod);
      end
      S_ERD: begin
        rd_en = 1'b1;
        ra0 = maddr(seg, k, cj);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_a <= mem[ra0];
      rd_b <= mem[ra1];
    end
  end

  always_comb begin
    o_push = (state == S_EWR) && !o_full;
    o_data.out_kind = seg;
    o_data.out_row = k[1:0];
    o_data.out_col = cj[1:0];
    o_data.out_value = rd_a;
    o_data.sweeps_done = sweep_count;
    o_data.converged = sweep_clean;
    o_data.last_result = seg && (k_inc == KW'(nc)) && (cj + CW'(1) == nc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sweep_count <= '0;
      sweep_clean <= 1'b1;
      k <= '0;
      ci <= '0;
      cj <= '0;
      seg <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!cmd_empty && cmd.item.last_elem) begin
            state <= S_VINIT;
            k <= '0;
            cj <= '0;
          end
        end
        S_VINIT: begin
          if (int'(cj) == MAX_COLS - 1) begin
            cj <= '0;
            k <= k_inc;
            if (int'(k) == MAX_COLS - 1) begin
              sweep_count <= '0;
              sweep_clean <= 1'b0;
              state <= (cfg.max_sweeps == '0) ? S_ERD : S_SWEEP;
              k <= '0;
              seg <= 1'b0;
            end
          end else begin
            cj <= cj + CW'(1);
          end
        end
        S_SWEEP: begin
          sweep_clean <= 1'b1;
          ci <= '0;
          cj <= CW'(1);
          k <= '0;
          seg <= 1'b0;
          ip <= '0;
          li <= '0;
          lj <= '0;
          state <= S_PRD;
        end
        S_PRD: state <= S_PWAIT;
        S_PWAIT: state <= S_PAA;
        S_PAA: begin
          ip <= sat_add(ip, prod);
          state <= S_PBB;
        end
        S_PBB: begin
          li <= sat_add(li, prod);
          state <= S_PACC;
        end
        S_PACC: begin
          lj <= sat_add(lj, prod);
          k <= k_inc;
          state <= (k_inc < nr) ? S_PRD : S_TEST;
        end
        S_TEST: begin
          if (q_abs < {24'd0, cfg.ortho_threshold}) begin
            state <= S_NEXT;
          end else begin
            sweep_clean <= 1'b0;
            swp <= swp_c;
            dn <= d_c;
            qn <= q_abs;
            neg <= ip[63] && (d_c != '0);
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (dn[63:30] != '0 || qn[63:30] != '0) begin
            dn <= dn >> 1;
            qn <= qn >> 1;
          end else if (qn == '0) begin
            tm <= '0;
            state <= S_TSQ;
          end else begin
            state <= S_DSQ;
          end
        end
        S_DSQ: state <= S_QSQ;
        S_QSQ: begin
          t64 <= prod;
          state <= S_RSQ;
        end
        S_RSQ: state <= S_RWAIT;
        S_RWAIT: begin
          if (!sq_busy) begin
            den <= {2'b00, dn[29:0]} + sq_root;
            state <= S_DIVST;
          end
        end
        S_DIVST: state <= S_TWAIT;
        S_TWAIT: begin
          if (!dv_busy) begin
            tm <= dv_quot;
            state <= S_TSQ;
          end
        end
        S_TSQ: state <= S_CSQ;
        S_CSQ: state <= S_CWAIT;
        S_CWAIT: begin
          if (!sq_busy) begin
            state <= S_CDIV;
          end
        end
        S_CDIV: begin
          if (!dv_busy) begin
            cs <= dv_quot;
            state <= S_SMUL;
          end
        end
        S_SMUL: state <= S_SSET;
        S_SSET: begin
          sn <= neg ? -$signed(sm_full[31:0]) : $signed(sm_full[31:0]);
          seg <= 1'b0;
          k <= '0;
          state <= S_RRD;
        end
        S_RRD: state <= S_RX;
        S_RX: state <= S_RY;
        S_RY: begin
          acc <= prod;
          state <= S_RA;
        end
        S_RA: state <= S_RB;
        S_RB: begin
          acc <= prod;
          state <= S_RW;
        end
        S_RW: begin
          if (k_inc < lim) begin
            k <= k_inc;
            state <= S_RRD;
          end else if (!seg) begin
            seg <= 1'b1;
            k <= '0;
            state <= S_RRD;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          seg <= 1'b0;
          k <= '0;
          ip <= '0;
          li <= '0;
          lj <= '0;
          if (cj + CW'(1) < nc) begin
            cj <= cj + CW'(1);
            state <= S_PRD;
          end else if (ci + CW'(2) < nc) begin
            ci <= ci + CW'(1);
            cj <= ci + CW'(2);
            state <= S_PRD;
          end else begin
            sweep_count <= count_inc;
            if (sweep_clean || count_inc == cfg.max_sweeps) begin
              cj <= '0;
              state <= S_ERD;
            end else begin
              state <= S_SWEEP;
            end
          end
        end
        S_ERD: state <= S_EWR;
        S_EWR: begin
          if (!o_full) begin
            state <= S_ERD;
            if (cj + CW'(1) < nc) begin
              cj <= cj + CW'(1);
            end else begin
              cj <= '0;
              if (k_inc < lim) begin
                k <= k_inc;
              end else if (!seg) begin
                seg <= 1'b1;
                k <= '0;
              end else begin
                seg <= 1'b0;
                k <= '0;
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/one_sided_jacobi_svd_core.sv
// channel   direction  handshake                  word
// item      in         push / full                element row, col, value, last flag
// result    out        pop / empty                kind, row, col, value, sweeps, converged, last
// cfg       in         cfg_valid / cfg_ready      register index and data, ready always high
//
// an element that is not last is written to the matrix store as it leaves the input queue
// a last element starts a run of sweeps over the column pairs; a rotated pair normalizes with up
// to 34 shifts and uses one root unit of 32 steps and one divider of 64 steps, each twice (once
// each when the tangent is zero); a pair below the threshold is skipped
// the v array is set to identity, max_cols by max_cols, at the start of every run
// each result word is read from the store and then pushed; a full output queue stalls the back end only
// reset is synchronous and clears control state; the matrix store is unset until written
module one_sided_jacobi_svd_core import jsvd_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int IN_DEPTH = IN_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  item_t       item,
  output logic        full,
  input  logic        pop,
  output res_t        result,
  output logic        empty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  logic cmd_empty;
  logic cmd_pop;
  logic o_push;
  res_t o_data;
  logic o_full;
  logic [$bits(res_t)-1:0] res_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows_used <= RESET_ROWS_USED;
      cfg.cols_used <= RESET_COLS_USED;
      cfg.ortho_threshold <= RESET_THRESHOLD;
      cfg.max_sweeps <= RESET_MAX_SWEEPS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS_USED: cfg.rows_used <= cfg_data[2:0];
        CFG_COLS_USED: cfg.cols_used <= cfg_data[2:0];
        CFG_THRESHOLD: cfg.ortho_threshold <= cfg_data;
        CFG_MAX_SWEEPS: cfg.max_sweeps <= cfg_data[7:0];
        default: cfg.max_sweeps <= cfg.max_sweeps;
      endcase
    end
  end

  jsvd_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .IN_DEPTH(IN_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  jsvd_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .o_push    (o_push),
    .o_data    (o_data),
    .o_full    (o_full)
  );

  jsvd_queue #(.W($bits(res_t)), .DEPTH(OUT_DEPTH)) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .din   (o_data),
    .full  (o_full),
    .pop   (pop),
    .dout  (res_bits),
    .empty (empty)
  );

  assign result = res_t'(res_bits);

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(o_push && o_full)) else $error("result pushed into full queue");

  a_last_is_v: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.last_result) |-> result.out_kind) else $error("last word not from v");

  a_converged_sweeps: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.converged) |-> (result.sweeps_done != 8'd0))
    else $error("converged without a sweep");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty) else $error("command popped from empty queue");

endmodule
